// ----- hdl/ivde_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivde_pkg
// Shared types and constants of the int8 vector distance engine.
// ----------------------------------------------------------------------------
package ivde_pkg;

    localparam int MaxDimDefault = 16384;

    typedef enum logic [1:0] {
        METRIC_L2  = 2'd0,
        METRIC_IP  = 2'd1,
        METRIC_COS = 2'd2,
        METRIC_L1  = 2'd3
    } metric_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MUL,
        ST_ROOT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accum;      // accumulate the accepted pair
        logic finish;     // latch result of the closing pair, clear sums
        logic prep;       // form d^2*2^60 and na*nb
        logic root_step;  // one bit of the cosine search
        logic root_init;  // start the bit search
    } cmd_t;

    typedef struct packed {
        logic is_cos;     // closing result needs the cosine search
        logic root_done;  // last bit decided
    } status_t;

endpackage

// ----- hdl/ivde_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivde_datapath
// Accumulators, result registers and bit-serial cosine search.
// ----------------------------------------------------------------------------
module ivde_datapath #(
    parameter int MAX_DIM = ivde_pkg::MaxDimDefault
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ivde_pkg::metric_t   metric,
    input  wire logic signed [7:0]   a_elem,
    input  wire logic signed [7:0]   b_elem,
    input  wire ivde_pkg::cmd_t      cmd,
    output ivde_pkg::status_t        status,
    output logic signed [30:0]       distance,
    output logic signed [31:0]       cosine,
    output logic                     valid_res,
    output logic                     too_long
);

    localparam int CntW = $clog2(MAX_DIM + 1);

    logic signed [31:0] main_sum_reg,  main_sum_next;
    logic        [28:0] norm_a_reg,    norm_a_next;
    logic        [28:0] norm_b_reg,    norm_b_next;
    logic [CntW-1:0]    count_reg,     count_next;
    logic               ovf_reg,       ovf_next;

    logic signed [31:0] main_sum_acc;
    logic        [28:0] norm_a_acc;
    logic        [28:0] norm_b_acc;
    logic [CntW-1:0]    count_acc;
    logic               ovf_acc;

    logic signed [31:0] dot_reg;
    logic        [28:0] na_reg, nb_reg;
    logic               neg_reg;
    logic [123:0]       rhs_reg;     // dot^2 * 2^60
    logic [123:0]       acc_reg;     // q^2 * na*nb
    logic [123:0]       qp_reg;      // q * na*nb shifted left by bit+1
    logic [123:0]       pp_reg;      // na*nb shifted left by 2*bit
    logic [30:0]        q_reg;
    logic [4:0]         bit_reg;
    logic [123:0]       trial;
    logic               fits;

    logic signed [8:0]  diff;
    logic signed [16:0] term;
    logic [8:0]         adiff;
    logic [30:0]        cand;
    logic [31:0]        mag;
    logic [30:0]        qf;
    logic [30:0]        qsat;

    assign diff  = 9'(a_elem) - 9'(b_elem);
    assign adiff = diff[8] ? 9'(-diff) : 9'(diff);

    always_comb
    begin
        unique case (metric)
            ivde_pkg::METRIC_L2: term = 17'(diff * diff);
            ivde_pkg::METRIC_L1: term = 17'({8'd0, adiff});
            default:             term = 17'(a_elem * b_elem);
        endcase
    end

    always_comb
    begin
        main_sum_acc = main_sum_reg;
        norm_a_acc   = norm_a_reg;
        norm_b_acc   = norm_b_reg;
        count_acc    = count_reg;
        ovf_acc      = ovf_reg;
        if (cmd.accum)
        begin
            if (count_reg < CntW'(MAX_DIM))
            begin
                main_sum_acc = main_sum_reg + 32'(term);
                norm_a_acc   = norm_a_reg + 29'(16'(a_elem * a_elem));
                norm_b_acc   = norm_b_reg + 29'(16'(b_elem * b_elem));
                count_acc    = count_reg + 1'b1;
            end
            else
            begin
                ovf_acc = 1'b1;
            end
        end
        main_sum_next = main_sum_acc;
        norm_a_next   = norm_a_acc;
        norm_b_next   = norm_b_acc;
        count_next    = count_acc;
        ovf_next      = ovf_acc;
        if (cmd.finish)
        begin
            main_sum_next = '0;
            norm_a_next   = '0;
            norm_b_next   = '0;
            count_next    = '0;
            ovf_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_sum_reg <= '0;
            norm_a_reg   <= '0;
            norm_b_reg   <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            main_sum_reg <= main_sum_next;
            norm_a_reg   <= norm_a_next;
            norm_b_reg   <= norm_b_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
        end
    end

    assign cand  = q_reg | (31'd1 << bit_reg);
    assign mag   = dot_reg[31] ? 32'(-dot_reg) : 32'(dot_reg);
    // (q + 2^bit)^2 * na*nb built from shifted partial terms
    assign trial = acc_reg + qp_reg + pp_reg;
    assign fits  = (trial <= rhs_reg);
    assign qf    = fits ? cand : q_reg;
    assign qsat  = (qf > 31'(1 << 30)) ? 31'(1 << 30) : qf;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            dot_reg   <= main_sum_acc;
            na_reg    <= norm_a_acc;
            nb_reg    <= norm_b_acc;
            neg_reg   <= main_sum_acc[31];
            too_long  <= ovf_acc;
            distance  <= main_sum_acc[30:0];
            cosine    <= '0;
            valid_res <= !(metric == ivde_pkg::METRIC_COS &&
                           (norm_a_acc == '0 || norm_b_acc == '0));
        end
        if (cmd.prep)
        begin
            rhs_reg <= {64'(mag * mag), 60'd0};
            pp_reg  <= {6'd0, 58'(na_reg * nb_reg), 60'd0};
        end
        if (cmd.root_init)
        begin
            q_reg   <= '0;
            bit_reg <= 5'd30;
            acc_reg <= '0;
            qp_reg  <= '0;
        end
        if (cmd.root_step)
        begin
            if (fits)
            begin
                q_reg   <= cand;
                acc_reg <= trial;
                qp_reg  <= (qp_reg >> 1) + pp_reg;
            end
            else
            begin
                qp_reg <= qp_reg >> 1;
            end
            pp_reg <= pp_reg >> 2;
            if (bit_reg != '0)
            begin
                bit_reg <= bit_reg - 1'b1;
            end
        end
        if (status.root_done && cmd.root_step)
        begin
            cosine <= neg_reg ? -32'(qsat) : 32'(qsat);
        end
    end

    assign status.is_cos    = (metric == ivde_pkg::METRIC_COS) &&
                              norm_a_acc != '0 && norm_b_acc != '0;
    assign status.root_done = (bit_reg == '0);

endmodule
`default_nettype wire

// ----- hdl/ivde_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivde_ctrl
// Sequencer: accumulate, run cosine search, hold result until taken.
// ----------------------------------------------------------------------------
module ivde_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic               last,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire ivde_pkg::status_t  status,
    output ivde_pkg::cmd_t          cmd
);

    ivde_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ivde_pkg::ST_ACCUM;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        logic take;
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        take          = 1'b0;
        unique case (state_reg)
            ivde_pkg::ST_ACCUM:
            begin
                s_axis_tready = 1'b1;
                take          = s_axis_tvalid;
            end
            ivde_pkg::ST_MUL:
            begin
                cmd.prep      = 1'b1;
                cmd.root_init = 1'b1;
                state_next    = ivde_pkg::ST_ROOT;
            end
            ivde_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_done)
                    state_next = ivde_pkg::ST_OUT;
            end
            ivde_pkg::ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                s_axis_tready = m_axis_tready;
                take          = m_axis_tready && s_axis_tvalid;
                if (m_axis_tready)
                    state_next = ivde_pkg::ST_ACCUM;
            end
            default: state_next = ivde_pkg::ST_ACCUM;
        endcase
        if (take)
        begin
            cmd.accum = 1'b1;
            if (last)
            begin
                cmd.finish = 1'b1;
                state_next = status.is_cos ? ivde_pkg::ST_MUL : ivde_pkg::ST_OUT;
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/int8_vector_distance_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int8_vector_distance_engine
// Streaming int8 distance: squared L2, inner product, cosine, L1.
// ----------------------------------------------------------------------------
// Use: pairs enter on s_axis, one per cycle while accumulating, tlast closes the vectors.
// One result per closing pair leaves on m_axis. cfg writes the metric; the user
// writes it only while idle, and the block itself does not enforce this.
// Throughput: one pair per cycle while accumulating. A result is registered
// from the closing pair and offered in the cycle after it; for cosine it follows
// a product step and a 31-step bit search of the root, one bit per cycle.
// While a result waits, the next pair is accepted in the cycle it is taken;
// a stalled receiver holds the result and blocks input.
// Reset clears sums, counters and sets the metric to squared L2.
// ----------------------------------------------------------------------------
module int8_vector_distance_engine #(
    parameter int MAX_DIM = ivde_pkg::MaxDimDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // a_elem[7:0], b_elem[15:8]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // distance[30:0], cosine[62:31]
    output logic [1:0]       m_axis_tuser,   // valid_res[0], too_long[1]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data
);

    ivde_pkg::metric_t metric_reg;
    ivde_pkg::cmd_t    cmd;
    ivde_pkg::status_t status;
    logic signed [30:0] distance;
    logic signed [31:0] cosine;
    logic valid_res, too_long;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            metric_reg <= ivde_pkg::METRIC_L2;
        else if (cfg_valid)
            metric_reg <= ivde_pkg::metric_t'(cfg_data);
    end

    ivde_ctrl u_ctrl (
        .clk, .rst_n, .s_axis_tvalid, .s_axis_tready, .last(s_axis_tlast),
        .m_axis_tvalid, .m_axis_tready, .status, .cmd
    );

    ivde_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
        .clk, .rst_n, .metric(metric_reg),
        .a_elem(s_axis_tdata[7:0]), .b_elem(s_axis_tdata[15:8]),
        .cmd, .status, .distance, .cosine, .valid_res, .too_long
    );

    assign m_axis_tdata = {1'b0, cosine, distance};
    assign m_axis_tuser = {too_long, valid_res};

endmodule
`default_nettype wire

// ----- hdl/ivde_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivde_checker
// Port-level checks of the distance engine.
// ----------------------------------------------------------------------------
module ivde_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while result stalled");

    a_cos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[62:31] == 32'd0)
        else $error("cosine set on invalid result");

endmodule

bind int8_vector_distance_engine ivde_checker u_chk (
    .clk, .rst_n, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata, .m_axis_tuser
);
